// ===== rtl/wsp_pkg.sv =====
// Shared types and constants for the world-to-screen projection pipeline
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

	localparam int COORD_W    = 32;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = COEF_W + COORD_W;
	localparam int FRAC_SHIFT = 28;
	localparam int CLIP_W     = 51;
	localparam int NUM_W      = CLIP_W + 1;
	localparam int SCALE_W    = 14;
	localparam int M_W        = NUM_W + SCALE_W;
	localparam int LIM_W      = M_W + 2;
	localparam int D_W        = CLIP_W + 1;
	localparam int R_W        = D_W + 1;
	localparam int LOW_W      = 16;
	localparam int Q_W        = 33;
	localparam int DIV_STEPS  = Q_W;
	localparam int SAT_SHIFT  = 15;
	localparam int ROW_W      = 64;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_ROW_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VP_W  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_VP_H  = 3'd4;

	localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] world_x;
		logic signed [COORD_W-1:0] world_y;
		logic signed [COORD_W-1:0] world_z;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic                      invalid;
	} out_item_t;

	typedef struct packed {
		logic [ROW_W-1:0]   row_x;
		logic [ROW_W-1:0]   row_y;
		logic [ROW_W-1:0]   row_w;
		logic [SCALE_W-1:0] vp_w;
		logic [SCALE_W-1:0] vp_h;
	} cfg_t;

	// one coordinate in flight through the divider
	typedef struct packed {
		logic [R_W-1:0]   r;
		logic [D_W-1:0]   d;
		logic [LOW_W-1:0] low;
		logic [Q_W-1:0]   q;
		logic             neg;
		logic             sat;
	} lane_t;

endpackage

`default_nettype wire

// ===== rtl/wsp_clip.sv =====
// Matrix rows times world point: products, then clip x, y, w sums
`timescale 1ns / 1ps
`default_nettype none

module wsp_clip (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     en,
	input  wire                                     v_in,
	input  wsp_pkg::in_item_t                       pt,
	input  wsp_pkg::cfg_t                           cfg,
	output logic                                    v_out,
	output logic signed [wsp_pkg::CLIP_W-1:0]       cx,
	output logic signed [wsp_pkg::CLIP_W-1:0]       cy,
	output logic signed [wsp_pkg::CLIP_W-1:0]       cw
);

	localparam int EXT_W = wsp_pkg::CLIP_W - wsp_pkg::COEF_W - wsp_pkg::FRAC_SHIFT;

	logic signed [wsp_pkg::COORD_W-1:0] p [3];
	logic [wsp_pkg::ROW_W-1:0]          rows [3];
	logic signed [wsp_pkg::PROD_W-1:0]  prod_c [3][3];
	logic signed [wsp_pkg::PROD_W-1:0]  prod_s1 [3][3];
	logic [wsp_pkg::COEF_W-1:0]         cst_s1 [3];
	logic                               v_s1;
	logic signed [wsp_pkg::CLIP_W-1:0]  sum_c [3];
	logic signed [wsp_pkg::CLIP_W-1:0]  sum_s2 [3];
	logic                               v_s2;

	assign p[0]    = pt.world_x;
	assign p[1]    = pt.world_y;
	assign p[2]    = pt.world_z;
	assign rows[0] = cfg.row_x;
	assign rows[1] = cfg.row_y;
	assign rows[2] = cfg.row_w;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				prod_c[r][k] = wsp_pkg::PROD_W'($signed(rows[r][wsp_pkg::COEF_W*k +: wsp_pkg::COEF_W]))
					* wsp_pkg::PROD_W'(p[k]);
			end
		end
	end

	// constant term is the Q4.12 coefficient shifted left 28 bits, i.e. Q11.40 at the clip sum width
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sum_c[r] = wsp_pkg::CLIP_W'(prod_s1[r][0]) + wsp_pkg::CLIP_W'(prod_s1[r][1])
				+ wsp_pkg::CLIP_W'(prod_s1[r][2])
				+ $signed({{EXT_W{cst_s1[r][wsp_pkg::COEF_W-1]}}, cst_s1[r],
					{wsp_pkg::FRAC_SHIFT{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r] <= prod_c[r];
				cst_s1[r]  <= rows[r][wsp_pkg::ROW_W-1 -: wsp_pkg::COEF_W];
				sum_s2[r]  <= sum_c[r];
			end
		end
	end

	assign v_out = v_s2;
	assign cx    = sum_s2[0];
	assign cy    = sum_s2[1];
	assign cw    = sum_s2[2];

endmodule

`default_nettype wire

// ===== rtl/wsp_prep.sv =====
// Numerators, viewport scaling and range check ahead of the divider
`timescale 1ns / 1ps
`default_nettype none

module wsp_prep (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     en,
	input  wire                                     v_in,
	input  wire signed [wsp_pkg::CLIP_W-1:0]        cx,
	input  wire signed [wsp_pkg::CLIP_W-1:0]        cy,
	input  wire signed [wsp_pkg::CLIP_W-1:0]        cw,
	input  wire [wsp_pkg::SCALE_W-1:0]              vp_w,
	input  wire [wsp_pkg::SCALE_W-1:0]              vp_h,
	output logic                                    v_out,
	output logic                                    zero_out,
	output wsp_pkg::lane_t [1:0]                    lanes
);

	logic signed [wsp_pkg::NUM_W-1:0] num_c [2];
	logic [wsp_pkg::NUM_W-1:0]        an_c [2];
	logic [wsp_pkg::CLIP_W-1:0]       acw_c;

	logic [wsp_pkg::NUM_W-1:0] an_s3 [2];
	logic [1:0]                neg_s3;
	logic [wsp_pkg::D_W-1:0]   d_s3;
	logic                      zero_s3;
	logic                      v_s3;

	logic [wsp_pkg::M_W-1:0]   m_s4 [2];
	logic [1:0]                neg_s4;
	logic [wsp_pkg::D_W-1:0]   d_s4;
	logic                      zero_s4;
	logic                      v_s4;

	logic [wsp_pkg::LIM_W-1:0] lim_c;
	wsp_pkg::lane_t [1:0]      lane_c;
	wsp_pkg::lane_t [1:0]      lane_s5;
	logic                      zero_s5;
	logic                      v_s5;

	always_comb begin
		num_c[0] = wsp_pkg::NUM_W'(cx) + wsp_pkg::NUM_W'(cw);
		num_c[1] = wsp_pkg::NUM_W'(cw) - wsp_pkg::NUM_W'(cy);
		for (int i = 0; i < 2; i++) begin
			an_c[i] = num_c[i][wsp_pkg::NUM_W-1] ? wsp_pkg::NUM_W'(-num_c[i])
				: wsp_pkg::NUM_W'(num_c[i]);
		end
		acw_c = cw[wsp_pkg::CLIP_W-1] ? wsp_pkg::CLIP_W'(-cw) : wsp_pkg::CLIP_W'(cw);
	end

	// quotient would pass 32768 once m >= 32769 * d
	always_comb begin
		lim_c = (wsp_pkg::LIM_W'(d_s4) << wsp_pkg::SAT_SHIFT) + wsp_pkg::LIM_W'(d_s4);
		for (int i = 0; i < 2; i++) begin
			lane_c[i].r   = wsp_pkg::R_W'(m_s4[i] >> wsp_pkg::LOW_W);
			lane_c[i].d   = d_s4;
			lane_c[i].low = m_s4[i][wsp_pkg::LOW_W-1:0];
			lane_c[i].q   = '0;
			lane_c[i].neg = neg_s4[i];
			lane_c[i].sat = wsp_pkg::LIM_W'(m_s4[i]) >= lim_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_in;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				an_s3[i]  <= an_c[i];
				neg_s3[i] <= num_c[i][wsp_pkg::NUM_W-1] ^ cw[wsp_pkg::CLIP_W-1];
			end
			d_s3    <= {acw_c, 1'b0};
			zero_s3 <= cw == '0;

			m_s4[0] <= wsp_pkg::M_W'(an_s3[0]) * wsp_pkg::M_W'(vp_w);
			m_s4[1] <= wsp_pkg::M_W'(an_s3[1]) * wsp_pkg::M_W'(vp_h);
			neg_s4  <= neg_s3;
			d_s4    <= d_s3;
			zero_s4 <= zero_s3;

			lane_s5 <= lane_c;
			zero_s5 <= zero_s4;
		end
	end

	assign v_out    = v_s5;
	assign zero_out = zero_s5;
	assign lanes    = lane_s5;

endmodule

`default_nettype wire

// ===== rtl/wsp_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, two lanes
`timescale 1ns / 1ps
`default_nettype none

module wsp_div (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   v_in,
	input  wire                   zero_in,
	input  wsp_pkg::lane_t [1:0]  lanes_in,
	output logic                  v_out,
	output logic                  zero_out,
	output wsp_pkg::lane_t [1:0]  lanes_out
);

	function automatic wsp_pkg::lane_t div_step(input wsp_pkg::lane_t l);
		wsp_pkg::lane_t      o;
		logic [wsp_pkg::R_W-1:0] rs;
		logic                ge;
		o   = l;
		rs  = {l.r[wsp_pkg::R_W-2:0], l.low[wsp_pkg::LOW_W-1]};
		ge  = rs >= wsp_pkg::R_W'(l.d);
		o.r = ge ? rs - wsp_pkg::R_W'(l.d) : rs;
		o.low = {l.low[wsp_pkg::LOW_W-2:0], 1'b0};
		o.q   = {l.q[wsp_pkg::Q_W-2:0], ge};
		return o;
	endfunction

	wsp_pkg::lane_t [1:0] src [wsp_pkg::DIV_STEPS];
	wsp_pkg::lane_t [1:0] lane_s [wsp_pkg::DIV_STEPS];
	logic                 zero_s [wsp_pkg::DIV_STEPS];
	logic                 valid_s [wsp_pkg::DIV_STEPS];

	for (genvar i = 0; i < wsp_pkg::DIV_STEPS; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign src[i] = lanes_in;
		end else begin : g_next
			assign src[i] = lane_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en) begin
				valid_s[i] <= (i == 0) ? v_in : valid_s[(i == 0) ? 0 : i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[i][0] <= div_step(src[i][0]);
				lane_s[i][1] <= div_step(src[i][1]);
				zero_s[i]    <= (i == 0) ? zero_in : zero_s[(i == 0) ? 0 : i-1];
			end
		end
	end

	assign v_out     = valid_s[wsp_pkg::DIV_STEPS-1];
	assign zero_out  = zero_s[wsp_pkg::DIV_STEPS-1];
	assign lanes_out = lane_s[wsp_pkg::DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/wsp_round.sv =====
// Rounding, saturation and the output register
`timescale 1ns / 1ps
`default_nettype none

module wsp_round (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   v_in,
	input  wire                   zero,
	input  wsp_pkg::lane_t [1:0]  lanes,
	output logic                  out_valid,
	output wsp_pkg::out_item_t    out_data
);

	// returns {flag, value}
	function automatic logic [wsp_pkg::COORD_W:0] finish(input wsp_pkg::lane_t l);
		logic [wsp_pkg::Q_W:0]     t;
		logic [wsp_pkg::Q_W-1:0]   qr;
		logic [wsp_pkg::COORD_W:0] res;
		t  = {1'b0, l.q} + (wsp_pkg::Q_W+1)'(1);
		qr = t[wsp_pkg::Q_W:1];
		if (l.sat) begin
			res = {1'b1, l.neg ? wsp_pkg::SAT_MIN : wsp_pkg::SAT_MAX};
		end else if (l.neg) begin
			if (qr > {1'b0, wsp_pkg::SAT_MIN}) begin
				res = {1'b1, wsp_pkg::SAT_MIN};
			end else begin
				res = {1'b0, wsp_pkg::COORD_W'(wsp_pkg::Q_W'(0) - qr)};
			end
		end else begin
			if (qr > {1'b0, wsp_pkg::SAT_MAX}) begin
				res = {1'b1, wsp_pkg::SAT_MAX};
			end else begin
				res = {1'b0, qr[wsp_pkg::COORD_W-1:0]};
			end
		end
		return res;
	endfunction

	logic [wsp_pkg::COORD_W:0] fx_c;
	logic [wsp_pkg::COORD_W:0] fy_c;
	wsp_pkg::out_item_t        res_c;

	always_comb begin
		fx_c = finish(lanes[0]);
		fy_c = finish(lanes[1]);
		if (zero) begin
			res_c.screen_x = '0;
			res_c.screen_y = '0;
			res_c.invalid  = 1'b1;
		end else begin
			res_c.screen_x = fx_c[wsp_pkg::COORD_W-1:0];
			res_c.screen_y = fy_c[wsp_pkg::COORD_W-1:0];
			res_c.invalid  = fx_c[wsp_pkg::COORD_W] | fy_c[wsp_pkg::COORD_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_in) begin
			out_data <= res_c;
		end
	end

	a_zero_w: assert property (@(posedge clk) disable iff (!arst_n)
		v_in && en && zero |=> out_data.invalid && out_data.screen_x == '0
			&& out_data.screen_y == '0)
		else $error("zero clip w did not give a flagged zero result");

	a_sat_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_in && en && (lanes[0].sat || lanes[1].sat) |=> out_data.invalid)
		else $error("saturated coordinate not flagged");

	a_valid_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_in && en |=> out_valid)
		else $error("item lost at output register");

endmodule

`default_nettype wire

// ===== rtl/world_to_screen_projection.sv =====
// Throughput: one point per cycle while the output side is ready; 2 clip
// stages, 3 prep stages, 33 divider stages (one quotient bit each) and the
// output register, all held by one stall.
// Reset clears every valid bit and loads matrix rows 0, viewport 1 x 1.
// Configuration writes complete in the cycle they are offered.
`timescale 1ns / 1ps
`default_nettype none

module world_to_screen_projection (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wsp_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output wsp_pkg::out_item_t                   out_data,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [wsp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [wsp_pkg::ROW_W-1:0]             cfg_data
);

	wsp_pkg::cfg_t                     cfg_q;
	logic                              en;
	logic                              clip_v;
	logic signed [wsp_pkg::CLIP_W-1:0] cx;
	logic signed [wsp_pkg::CLIP_W-1:0] cy;
	logic signed [wsp_pkg::CLIP_W-1:0] cw;
	logic                              prep_v;
	logic                              prep_zero;
	wsp_pkg::lane_t [1:0]              prep_lanes;
	logic                              div_v;
	logic                              div_zero;
	wsp_pkg::lane_t [1:0]              div_lanes;

	// whole pipe moves unless a finished result is stuck at the output
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_x <= '0;
			cfg_q.row_y <= '0;
			cfg_q.row_w <= '0;
			cfg_q.vp_w  <= wsp_pkg::SCALE_W'(1);
			cfg_q.vp_h  <= wsp_pkg::SCALE_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wsp_pkg::CFG_ROW_X: cfg_q.row_x <= cfg_data;
				wsp_pkg::CFG_ROW_Y: cfg_q.row_y <= cfg_data;
				wsp_pkg::CFG_ROW_W: cfg_q.row_w <= cfg_data;
				wsp_pkg::CFG_VP_W:  cfg_q.vp_w  <= cfg_data[wsp_pkg::SCALE_W-1:0];
				wsp_pkg::CFG_VP_H:  cfg_q.vp_h  <= cfg_data[wsp_pkg::SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	wsp_clip u_clip (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en),
		.v_in  (in_valid),
		.pt    (in_data),
		.cfg   (cfg_q),
		.v_out (clip_v),
		.cx    (cx),
		.cy    (cy),
		.cw    (cw)
	);

	wsp_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_in    (clip_v),
		.cx      (cx),
		.cy      (cy),
		.cw      (cw),
		.vp_w    (cfg_q.vp_w),
		.vp_h    (cfg_q.vp_h),
		.v_out   (prep_v),
		.zero_out(prep_zero),
		.lanes   (prep_lanes)
	);

	wsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (prep_v),
		.zero_in  (prep_zero),
		.lanes_in (prep_lanes),
		.v_out    (div_v),
		.zero_out (div_zero),
		.lanes_out(div_lanes)
	);

	wsp_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.v_in     (div_v),
		.zero     (div_zero),
		.lanes    (div_lanes),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

// ===== verif/world_to_screen_projection_tb.sv =====
// Self-checking bench for the world-to-screen projection pipeline
`timescale 1ns / 1ps

module world_to_screen_projection_tb;

	localparam int PIPE_LAT = 39;
	// an index past the register list; writes to it are dropped
	localparam logic [wsp_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	// expected screen positions, oldest first
	class screen_scoreboard;
		logic [63:0] row_x, row_y, row_w;
		logic [13:0] vp_w, vp_h;
		wsp_pkg::out_item_t pending[$];
		int errors;
		int checked;

		function new();
			row_x = '0; row_y = '0; row_w = '0; vp_w = 14'd1; vp_h = 14'd1;
			errors = 0; checked = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [63:0] val);
			case (idx)
				wsp_pkg::CFG_ROW_X: row_x = val;
				wsp_pkg::CFG_ROW_Y: row_y = val;
				wsp_pkg::CFG_ROW_W: row_w = val;
				wsp_pkg::CFG_VP_W:  vp_w = val[13:0];
				wsp_pkg::CFG_VP_H:  vp_h = val[13:0];
				default: ;
			endcase
		endfunction

		function logic signed [63:0] clip_dot(logic [63:0] row, wsp_pkg::in_item_t p);
			logic signed [63:0] acc;
			acc = 64'(signed'(row[63:48])) <<< 28;
			acc += 64'(signed'(row[15:0])) * 64'(p.world_x);
			acc += 64'(signed'(row[31:16])) * 64'(p.world_y);
			acc += 64'(signed'(row[47:32])) * 64'(p.world_z);
			return acc;
		endfunction

		// round(num*scale/(2*cw)) in Q16.16, ties away from zero, saturated
		function logic [31:0] to_screen(logic signed [63:0] num, logic signed [63:0] cw,
				logic [13:0] scale, ref logic sat);
			logic neg;
			logic [127:0] m, d, q, r;
			neg = (num < 0) != (cw < 0);
			d = 128'(cw < 0 ? -cw : cw) << 1;
			m = 128'(num < 0 ? -num : num) * 128'(scale);
			q = m / d;
			r = m % d;
			if (q > 128'd32768) begin
				sat = 1'b1;
				return neg ? wsp_pkg::SAT_MIN : wsp_pkg::SAT_MAX;
			end
			q = (((q << 17) | ((r << 17) / d)) + 1) >> 1;
			if (neg) begin
				if (q > 128'h8000_0000) begin
					sat = 1'b1;
					return wsp_pkg::SAT_MIN;
				end
				return 32'(-q);
			end
			if (q > 128'h7FFF_FFFF) begin
				sat = 1'b1;
				return wsp_pkg::SAT_MAX;
			end
			return q[31:0];
		endfunction

		function void note_point(wsp_pkg::in_item_t p);
			logic signed [63:0] cx, cy, cw;
			wsp_pkg::out_item_t e;
			logic sat;
			cx = clip_dot(row_x, p);
			cy = clip_dot(row_y, p);
			cw = clip_dot(row_w, p);
			sat = 1'b0;
			e = '0;
			if (cw == 0) sat = 1'b1;
			else begin
				e.screen_x = to_screen(cx + cw, cw, vp_w, sat);
				e.screen_y = to_screen(cw - cy, cw, vp_h, sat);
			end
			e.invalid = sat;
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(wsp_pkg::out_item_t a);
			wsp_pkg::out_item_t e;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.screen_x !== e.screen_x) begin
				$error("screen_x expected %h got %h", e.screen_x, a.screen_x);
				errors++;
			end
			if (a.screen_y !== e.screen_y) begin
				$error("screen_y expected %h got %h", e.screen_y, a.screen_y);
				errors++;
			end
			if (a.invalid !== e.invalid) begin
				$error("invalid expected %b got %b", e.invalid, a.invalid);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	wsp_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wsp_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [wsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [wsp_pkg::ROW_W-1:0] cfg_data = '0;

	screen_scoreboard sb;
	int sink_idle_pct = 0;
	int hold_off = 0;
	int points_sent = 0;

	world_to_screen_projection uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	task automatic send_point(wsp_pkg::in_item_t p, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data <= p;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_point(p);
		points_sent++;
		@(negedge clk);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(5))
			0: return 16'h1000;
			1: return 16'hF000;
			2: return 16'(signed'($urandom_range(4095)) - 2048);
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_row();
		return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(4))
			0: return 32'(signed'($urandom_range(20 << 16)) - (10 << 16));
			1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n, int idle_pct);
		wsp_pkg::in_item_t p;
		repeat (n) begin
			p.world_x = rand_coord();
			p.world_y = rand_coord();
			p.world_z = rand_coord();
			send_point(p, idle_pct);
		end
		stop_sending();
	endtask

	initial begin
		wsp_pkg::in_item_t p;
		sb = new();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset state: all rows zero, so clip w is zero
		send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 0);
		stop_sending();
		drain();

		// identity-like perspective: w = z, x = x, y = y
		write_reg(wsp_pkg::CFG_ROW_X, 64'h0000_0000_0000_1000);
		write_reg(wsp_pkg::CFG_ROW_Y, 64'h0000_0000_1000_0000);
		write_reg(wsp_pkg::CFG_ROW_W, 64'h0000_1000_0000_0000);
		write_reg(wsp_pkg::CFG_VP_W, 64'd8192);
		write_reg(wsp_pkg::CFG_VP_H, 64'd1);
		write_reg(CFG_UNUSED, 64'hFFFF);
		sink_idle_pct = 23;
		send_point('{32'h0, 32'h0, 32'h0001_0000}, 0);
		send_point('{32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000}, 0);
		send_point('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001}, 0);
		send_point('{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 0);
		send_point('{32'h0, 32'h0, 32'h0}, 0);
		send_point('{32'h0000_8000, 32'h0000_8000, 32'h8000_0000}, 0);
		send_point('{32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF}, 0);
		send_point('{32'h0000_0001, 32'h0000_0003, 32'h0000_0004}, 0);
		stop_sending();
		drain();
		write_reg(wsp_pkg::CFG_ROW_W, 64'h8000_7FFF_7FFF_7FFF);
		write_reg(wsp_pkg::CFG_ROW_X, 64'h7FFF_8000_8000_8000);
		write_reg(wsp_pkg::CFG_VP_W, 64'd0);
		write_reg(wsp_pkg::CFG_VP_H, 64'd16383);
		send_point('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0);
		send_point('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0);
		send_point('{32'h0001_0000, 32'h0, 32'h0}, 0);
		stop_sending();
		drain();

		// random settings; one phase runs without any idling
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(wsp_pkg::CFG_ROW_X, rand_row());
			write_reg(wsp_pkg::CFG_ROW_Y, rand_row());
			write_reg(wsp_pkg::CFG_ROW_W, {16'h1000 + rand_coef(), rand_coef(),
				rand_coef(), rand_coef()});
			write_reg(wsp_pkg::CFG_VP_W,
				ph == 0 ? 64'd8192 : 64'($urandom_range(8192, 1)));
			write_reg(wsp_pkg::CFG_VP_H,
				ph == 1 ? 64'd1 : 64'($urandom_range(8192, 1)));
			sink_idle_pct = (ph == 3) ? 0 : 23;
			if (ph == 5) begin
				// back-pressure: outputs stall while inputs keep coming
				@(negedge clk);
				hold_off = 150;
			end
			random_phase(80, (ph == 3) ? 0 : 23);
			drain();
		end

		$display("Covered %0d points over 11 register settings, incl. w = 0,", points_sent);
		$display("saturation, zero/oversize viewports and a long output stall.");
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/wsp_pkg.sv
rtl/wsp_clip.sv
rtl/wsp_prep.sv
rtl/wsp_div.sv
rtl/wsp_round.sv
rtl/world_to_screen_projection.sv
verif/world_to_screen_projection_tb.sv
